[rtl/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared types, round constants and initial chaining values.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // Word queue between the front and the compression core.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Round counter: 80 rounds, the first 16 take their word from the queue.
  localparam int            ROUND_W     = 7;
  localparam logic [6:0]    LOAD_ROUNDS = 7'd16;
  localparam logic [6:0]    ROUND_F2    = 7'd20;
  localparam logic [6:0]    ROUND_F3    = 7'd40;
  localparam logic [6:0]    ROUND_F4    = 7'd60;
  localparam logic [6:0]    LAST_ROUND  = 7'd79;

  // Padding constants.
  localparam logic [7:0]    PAD_BYTE     = 8'h80;
  localparam logic [3:0]    LEN_WORD_IDX = 4'd14;

  // Digest output index of the final word.
  localparam logic [2:0]    LAST_OUT_IDX = 3'd4;

  // Round constants.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Initial chaining values.
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // One queue entry: a message word, or the end-of-message marker.
  typedef struct packed {
    logic        done_mark;
    logic [31:0] word;
  } qent_t;

  // Push side of the queue.
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qpush_t;

  // Head of the queue as seen by the core.
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

  typedef enum logic [2:0] {
    F_ACCEPT,
    F_PAD_FIRST,
    F_PAD_ZERO,
    F_LEN_HI,
    F_LEN_LO,
    F_DONE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_ADD,
    B_OUT
  } back_state_t;

endpackage

[rtl/sha1_queue.sv]
// ----------------------------------------------------------------------------
// SHA-1 word queue
// Small FIFO of message words and end markers between front and core.
// ----------------------------------------------------------------------------
module sha1_queue (
  input  logic             clk,
  input  logic             rst,
  input  sha1_pkg::qpush_t push,
  output logic             full,
  input  logic             pop,
  output sha1_pkg::qhead_t head
);

  sha1_pkg::qent_t               entries [sha1_pkg::QUEUE_DEPTH];
  logic [sha1_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [sha1_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [sha1_pkg::QUEUE_AW:0]   count;
  logic                          do_push;
  logic                          do_pop;

  // Status and head view.
  assign full       = (count == (sha1_pkg::QUEUE_AW+1)'(sha1_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.ent   = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (sha1_pkg::QUEUE_AW+1)'(do_push) - (sha1_pkg::QUEUE_AW+1)'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.ent;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (sha1_pkg::QUEUE_AW+1)'(sha1_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");
  a_pop_track: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");
  a_push_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on push");
`endif

endmodule

[rtl/sha1_front.sv]
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts byte beats, packs big-endian words, counts length and pads.
// ----------------------------------------------------------------------------
module sha1_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic             byte_valid,
  input  logic             message_end,
  output sha1_pkg::qpush_t push,
  input  logic             full
);

  sha1_pkg::front_state_t state;
  sha1_pkg::front_state_t state_next;
  logic [5:0]             count;
  logic [5:0]             count_next;
  logic [31:0]            acc;
  logic [31:0]            acc_next;
  logic [63:0]            bit_length;
  logic [63:0]            bit_length_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::F_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // Byte count, length and word accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      bit_length <= '0;
    end else begin
      count      <= count_next;
      bit_length <= bit_length_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // Next state, word packing and padding generation.
  always_comb begin
    logic [1:0]  pos;
    logic [31:0] word_b;
    state_next      = state;
    count_next      = count;
    acc_next        = acc;
    bit_length_next = bit_length;
    push            = '0;
    in_ready        = 1'b0;
    pos             = count[1:0];
    word_b          = (pos == 2'd0) ? 32'd0 : acc;
    unique case (state)
      sha1_pkg::F_ACCEPT: begin
        in_ready = !full;
        if (in_valid && !full) begin
          if (byte_valid) begin
            word_b[{~pos, 3'b000} +: 8] = data_byte;
            acc_next        = word_b;
            bit_length_next = bit_length + 64'd8;
            count_next      = count + 6'd1;
            if (pos == 2'd3) begin
              push.valid          = 1'b1;
              push.ent.done_mark  = 1'b0;
              push.ent.word       = word_b;
            end
          end
          if (message_end) begin
            state_next = sha1_pkg::F_PAD_FIRST;
          end
        end
      end
      sha1_pkg::F_PAD_FIRST: begin
        // Word holding the pending bytes, then the 0x80 marker and zeros.
        if (!full) begin
          word_b[{~pos, 3'b000} +: 8] = sha1_pkg::PAD_BYTE;
          push.valid         = 1'b1;
          push.ent.done_mark = 1'b0;
          push.ent.word      = word_b;
          count_next         = {count[5:2] + 4'd1, 2'b00};
          state_next         = sha1_pkg::F_PAD_ZERO;
        end
      end
      sha1_pkg::F_PAD_ZERO: begin
        // Zero words until the length slot, wrapping into a new block if needed.
        if (count[5:2] == sha1_pkg::LEN_WORD_IDX) begin
          state_next = sha1_pkg::F_LEN_HI;
        end else if (!full) begin
          push.valid         = 1'b1;
          push.ent.done_mark = 1'b0;
          push.ent.word      = 32'd0;
          count_next         = {count[5:2] + 4'd1, 2'b00};
        end
      end
      sha1_pkg::F_LEN_HI: begin
        if (!full) begin
          push.valid         = 1'b1;
          push.ent.done_mark = 1'b0;
          push.ent.word      = bit_length[63:32];
          state_next         = sha1_pkg::F_LEN_LO;
        end
      end
      sha1_pkg::F_LEN_LO: begin
        if (!full) begin
          push.valid         = 1'b1;
          push.ent.done_mark = 1'b0;
          push.ent.word      = bit_length[31:0];
          state_next         = sha1_pkg::F_DONE;
        end
      end
      sha1_pkg::F_DONE: begin
        // End marker tells the core to emit the digest; start a fresh message.
        if (!full) begin
          push.valid         = 1'b1;
          push.ent.done_mark = 1'b1;
          push.ent.word      = 32'd0;
          count_next         = '0;
          bit_length_next    = '0;
          state_next         = sha1_pkg::F_ACCEPT;
        end
      end
      default: begin
        state_next = sha1_pkg::F_ACCEPT;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_pad_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == sha1_pkg::F_PAD_ZERO) |-> (count[1:0] == 2'd0))
    else $error("padding word index not aligned");
  a_len_slot: assert property (@(posedge clk) disable iff (rst)
    (state == sha1_pkg::F_LEN_HI) |-> (count[5:2] == sha1_pkg::LEN_WORD_IDX))
    else $error("length word outside its slot");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push while queue full");
`endif

endmodule

[rtl/sha1_core.sv]
// ----------------------------------------------------------------------------
// SHA-1 compression core
// One round per cycle over queued words, stalling on an empty queue; chain update and digest output.
// ----------------------------------------------------------------------------
module sha1_core (
  input  logic             clk,
  input  logic             rst,
  input  sha1_pkg::qhead_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      digest_word,
  output logic             digest_last
);

  sha1_pkg::back_state_t        state;
  sha1_pkg::back_state_t        state_next;
  logic [sha1_pkg::ROUND_W-1:0] round;
  logic [31:0]                  va, vb, vc, vd, ve;
  logic [31:0]                  window [16];
  logic [31:0]                  chain [5];
  logic [2:0]                   out_idx;
  logic                         do_start;
  logic                         do_round;
  logic                         do_add;
  logic                         do_done;
  logic                         out_load;
  logic [31:0]                  w_mix;
  logic [31:0]                  w_new;
  logic [31:0]                  w_cur;
  logic [31:0]                  f_val;
  logic [31:0]                  k_val;
  logic [31:0]                  t_sum;

  // Message schedule and round function.
  assign w_mix = window[13] ^ window[8] ^ window[2] ^ window[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign w_cur = (round < sha1_pkg::LOAD_ROUNDS) ? head.ent.word : w_new;

  always_comb begin
    priority if (round < sha1_pkg::ROUND_F2) begin
      f_val = (vb & vc) | (~vb & vd);
      k_val = sha1_pkg::K0;
    end else if (round < sha1_pkg::ROUND_F3) begin
      f_val = vb ^ vc ^ vd;
      k_val = sha1_pkg::K1;
    end else if (round < sha1_pkg::ROUND_F4) begin
      f_val = (vb & vc) | (vb & vd) | (vc & vd);
      k_val = sha1_pkg::K2;
    end else begin
      f_val = vb ^ vc ^ vd;
      k_val = sha1_pkg::K3;
    end
  end

  assign t_sum = {va[26:0], va[31:27]} + f_val + ve + k_val + w_cur;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: start a block, run rounds, fold into chain, emit digest.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_start   = 1'b0;
    do_round   = 1'b0;
    do_add     = 1'b0;
    do_done    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      sha1_pkg::B_IDLE: begin
        if (head.valid) begin
          if (head.ent.done_mark) begin
            pop        = 1'b1;
            do_done    = 1'b1;
            state_next = sha1_pkg::B_OUT;
          end else begin
            do_start   = 1'b1;
            state_next = sha1_pkg::B_RUN;
          end
        end
      end
      sha1_pkg::B_RUN: begin
        if (round < sha1_pkg::LOAD_ROUNDS) begin
          pop      = head.valid;
          do_round = head.valid;
        end else begin
          do_round = 1'b1;
        end
        if (do_round && round == sha1_pkg::LAST_ROUND) begin
          state_next = sha1_pkg::B_ADD;
        end
      end
      sha1_pkg::B_ADD: begin
        do_add     = 1'b1;
        state_next = sha1_pkg::B_IDLE;
      end
      sha1_pkg::B_OUT: begin
        out_load = !out_valid || out_ready;
        if (out_load && out_idx == sha1_pkg::LAST_OUT_IDX) begin
          state_next = sha1_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = sha1_pkg::B_IDLE;
      end
    endcase
  end

  // Round counter, output index and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      round     <= '0;
      out_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_start) begin
        round <= '0;
      end else if (do_round) begin
        round <= round + 1'b1;
      end
      if (do_done) begin
        out_idx <= '0;
      end else if (out_load) begin
        out_idx <= out_idx + 3'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Chaining words: reset to initial values, updated after each block, restored after the digest.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1_pkg::H_INIT[i];
      end
    end else if (do_add) begin
      chain[0] <= chain[0] + va;
      chain[1] <= chain[1] + vb;
      chain[2] <= chain[2] + vc;
      chain[3] <= chain[3] + vd;
      chain[4] <= chain[4] + ve;
    end else if (out_load && out_idx == sha1_pkg::LAST_OUT_IDX) begin
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1_pkg::H_INIT[i];
      end
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk) begin
    if (do_start) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (do_round) begin
      va <= t_sum;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i+1];
      end
      window[15] <= w_cur;
    end
  end

  // Digest output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_word <= chain[out_idx];
      digest_last <= (out_idx == sha1_pkg::LAST_OUT_IDX);
    end
  end

`ifndef SYNTHESIS
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sha1_pkg::B_RUN) |-> (round <= sha1_pkg::LAST_ROUND))
    else $error("round counter past last round");
  a_no_marker_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == sha1_pkg::B_RUN && round < sha1_pkg::LOAD_ROUNDS && head.valid)
      |-> !head.ent.done_mark)
    else $error("end marker inside a block");
  a_chain_restart: assert property (@(posedge clk) disable iff (rst)
    (state == sha1_pkg::B_OUT && out_load && out_idx == sha1_pkg::LAST_OUT_IDX)
      |=> (chain[0] == sha1_pkg::H_INIT[0] && state == sha1_pkg::B_IDLE))
    else $error("chain not restored after digest");
`endif

endmodule

[rtl/sha1_stream_hasher.sv]
// After the closing beat, the padding words are queued, each padded block is compressed,
// and the first digest word then appears through the output register.
// Throughput: one byte beat per cycle while the front is accepting and the word queue has room;
// the sustained rate is set by the core, which runs a start, 80 rounds and a fold per 64 bytes.
// Reset: synchronous rst clears the front, queue and sequencer and loads the initial
// chaining values; the block is ready for beats as soon as reset is released.
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-stream SHA-1 with a packing front end, word queue and round core.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  sha1_pkg::qpush_t push;
  sha1_pkg::qhead_t head;
  logic             full;
  logic             pop;

  // Front end: byte beats to words and padding.
  sha1_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .message_end (message_end),
    .push        (push),
    .full        (full)
  );

  // Queue between front end and core.
  sha1_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .pop  (pop),
    .head (head)
  );

  // Compression core and digest output.
  sha1_core u_core (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .digest_last (digest_last)
  );

endmodule
